[rtl/ocwd_pkg.sv]
// Package for the octree child context word pipeline: payload and stage types.
`timescale 1ns / 1ps
package ocwd_pkg;

   localparam int WordWidth    = 12;
   localparam int PatternWidth = 6;

   localparam logic [3:0] SelTriple = 4'b1000;
   localparam logic [3:0] SelLb     = 4'b0100;
   localparam logic [3:0] SelFb     = 4'b0101;
   localparam logic [3:0] SelLf     = 4'b0110;
   localparam logic [3:0] SelFront  = 4'b0001;
   localparam logic [3:0] SelBottom = 4'b0010;

   typedef struct packed {
      logic [5:0] neigh_pattern;
      logic [7:0] occ_left;
      logic [7:0] occ_front;
      logic [7:0] occ_bottom;
      logic [7:0] occ_left_bottom;
      logic [7:0] occ_front_bottom;
      logic [7:0] occ_left_front;
      logic       left_bottom_present;
      logic       front_bottom_present;
      logic       left_front_present;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] word0;
      logic [WordWidth-1:0] word1;
      logic [WordWidth-1:0] word2;
      logic [WordWidth-1:0] word3;
      logic [WordWidth-1:0] word4;
      logic [WordWidth-1:0] word5;
      logic [WordWidth-1:0] word6;
      logic [WordWidth-1:0] word7;
      logic [6:0]           sparse_mask;
   } rsp_type;

   // pattern, gated neighbour bytes, the halves that touch the node and edge bits
   typedef struct packed {
      logic [PatternWidth-1:0] np;
      logic [7:0]              fl;
      logic [7:0]              ff;
      logic [7:0]              fb;
      logic [3:0]              a_l;
      logic [3:0]              a_f;
      logic [3:0]              a_b;
      logic [7:0]              any_occ;
      logic [5:0]              edge_occ;
   } feat_type;

   typedef struct packed {
      feat_type   feat;
      logic       cnt_many;
      logic       cnt_some;
      logic [1:0] cnt_n;
   } cntd_type;

endpackage

[rtl/ocwd_prep.sv]
// First stage: gate neighbour bytes and extract adjacent halves and edge bits.
`timescale 1ns / 1ps
module ocwd_prep (
   input  ocwd_pkg::req_type  req_data,
   output ocwd_pkg::feat_type feat
);

   logic [7:0] fl;
   logic [7:0] ff;
   logic [7:0] fb;
   logic [7:0] e_lb;
   logic [7:0] e_fb;
   logic [7:0] e_lf;

   always_comb begin
      fl   = req_data.neigh_pattern[1] ? req_data.occ_left : 8'd0;
      ff   = req_data.neigh_pattern[2] ? req_data.occ_front : 8'd0;
      fb   = req_data.neigh_pattern[4] ? req_data.occ_bottom : 8'd0;
      e_lb = req_data.left_bottom_present ? req_data.occ_left_bottom : 8'd0;
      e_fb = req_data.front_bottom_present ? req_data.occ_front_bottom : 8'd0;
      e_lf = req_data.left_front_present ? req_data.occ_left_front : 8'd0;

      feat.np       = req_data.neigh_pattern;
      feat.fl       = fl;
      feat.ff       = ff;
      feat.fb       = fb;
      feat.a_l      = fl[7:4];
      feat.a_f      = {ff[7:6], ff[3:2]};
      feat.a_b      = {fb[7], fb[5], fb[3], fb[1]};
      feat.any_occ  = fl | ff | fb;
      feat.edge_occ = {e_lf[7:6], e_fb[7], e_fb[3], e_lb[7], e_lb[5]};
   end

endmodule

[rtl/ocwd_count.sv]
// Second stage: count occupied adjacent children and non-empty neighbour halves.
`timescale 1ns / 1ps
module ocwd_count (
   input  ocwd_pkg::feat_type feat,
   output ocwd_pkg::cntd_type cntd
);

   logic [3:0] cnt;
   logic [1:0] cnt_n;

   always_comb begin
      cnt = 4'd0;
      for (int i = 0; i < 4; i++) begin
         cnt = cnt + {3'd0, feat.a_l[i]} + {3'd0, feat.a_f[i]} + {3'd0, feat.a_b[i]};
      end
      cnt_n = {1'b0, |feat.a_l} + {1'b0, |feat.a_f} + {1'b0, |feat.a_b};

      cntd.feat     = feat;
      cntd.cnt_many = (cnt > 4'd1);
      cntd.cnt_some = (cnt != 4'd0);
      cntd.cnt_n    = cnt_n;
   end

endmodule

[rtl/ocwd_words.sv]
// Third stage: form the eight child context words and the sparse mask.
`timescale 1ns / 1ps
module ocwd_words (
   input  ocwd_pkg::cntd_type cntd,
   output ocwd_pkg::rsp_type  rsp
);

   ocwd_pkg::feat_type f;
   logic       nl;
   logic       nf;
   logic       nb;
   logic [2:0] n3;
   logic [1:0] n2;
   logic [2:0] lfb;
   logic [11:0] w0;
   logic [11:0] w1;
   logic [11:0] w2;
   logic [11:0] w3;
   logic [11:0] w4;
   logic [11:0] w5;
   logic [11:0] w6;
   logic [6:0]  sp;

   always_comb begin
      f   = cntd.feat;
      nl  = |f.a_l;
      nf  = |f.a_f;
      nb  = |f.a_b;
      n3  = {f.np[5], f.np[3], f.np[0]};
      n2  = n3[1:0];
      lfb = {f.np[4], f.np[2], f.np[1]};
      sp  = 7'd0;

      // child 0
      w0 = 12'd0;
      if (cntd.cnt_many) begin
         if (cntd.cnt_n == 2'd3) begin
            w0 = {ocwd_pkg::SelTriple, 8'd0}
               | {3'd0, f.a_b[2:0], f.a_f[2:0], f.a_l[2:0]};
         end else if (cntd.cnt_n == 2'd2) begin
            if (nl && nf) begin
               w0 = {ocwd_pkg::SelLf, f.a_f, f.a_l};
            end else if (nf && nb) begin
               w0 = {ocwd_pkg::SelFb, f.a_b, f.a_f};
            end else begin
               w0 = {ocwd_pkg::SelLb, f.a_b, f.a_l};
            end
         end else begin
            if (nb) begin
               w0 = {ocwd_pkg::SelBottom, f.a_b, f.edge_occ[5:4], 2'd0};
            end else if (nf) begin
               w0 = {ocwd_pkg::SelFront, f.a_f, f.edge_occ[1:0], 2'd0};
            end else if (nl) begin
               w0 = {4'd0, f.a_l, f.edge_occ[3:2], 2'd0};
            end
         end
      end else begin
         w0[6:4] = lfb;
         if (cntd.cnt_some) begin
            if (nb) begin
               w0[8:7] = 2'd3;
            end else if (nf) begin
               w0[8:7] = 2'd2;
            end else if (nl) begin
               w0[8:7] = 2'd1;
            end
         end
         if (lfb != 3'd0) begin
            if (f.any_occ[0]) begin
               w0[3:0] = {1'b1, f.fb[0], f.ff[0], f.fl[0]};
            end else begin
               w0[0] = f.fl[1] | f.ff[4] | f.fb[4];
               w0[1] = f.fl[2] | f.ff[1] | f.fb[2];
               w0[2] = ~|f.edge_occ;
            end
         end else begin
            w0[1] = ~|f.edge_occ[1:0];
            w0[2] = ~|f.edge_occ[3:2];
            w0[3] = ~|f.edge_occ[5:4];
         end
         sp[0] = 1'b1;
      end

      // child 1
      w1 = 12'd0;
      if (nl || nf) begin
         w1 = {1'b0, f.a_f, f.a_l, n3};
      end else begin
         w1[5] = n3[2];
         if (f.any_occ[1]) begin
            w1[4:1] = {1'b1, f.fb[1], f.ff[1], f.fl[1]};
         end else begin
            w1[1] = f.fl[0] | f.ff[0];
            w1[2] = f.fl[3] | f.ff[5];
            w1[3] = ~(f.edge_occ[0] | f.edge_occ[2] | f.edge_occ[4] | f.edge_occ[5]);
         end
         w1[0] = ~nb;
         sp[1] = 1'b1;
      end

      // child 2
      w2 = 12'd0;
      if (nl || nb) begin
         w2 = {2'd0, f.a_b, f.a_l, n2};
      end else begin
         w2[0] = ~nf;
         if (f.any_occ[2]) begin
            w2[4:1] = {1'b1, f.fl[2], f.fb[2], f.ff[2]};
         end else begin
            w2[3] = f.fl[0] | f.fb[0];
            w2[2] = f.fl[3] | f.fb[6];
            w2[1] = ~|f.edge_occ[1:0];
         end
         w2[5] = n2[1];
         sp[2] = 1'b1;
      end

      // child 3
      w3 = 12'd0;
      if (nl) begin
         w3 = {5'd0, f.a_l, n3};
      end else begin
         w3[0] = ~nf;
         w3[1] = ~nb;
         if (f.any_occ[3]) begin
            w3[5:2] = {1'b1, f.fb[3], f.ff[3], f.fl[3]};
         end else begin
            w3[4:3] = f.fl[2:1];
            w3[2]   = ~(f.edge_occ[1] | f.edge_occ[4] | f.edge_occ[5]);
         end
         w3[7:6] = n3[2:1];
         sp[3] = 1'b1;
      end

      // child 4
      w4 = 12'd0;
      if (nf || nb) begin
         w4 = {4'd0, f.a_b[3:2], f.a_b[0], f.a_f[3:2], f.a_f[0], n2};
      end else begin
         w4[0] = ~nl;
         if (f.any_occ[4]) begin
            w4[4:1] = {1'b1, f.ff[4], f.fb[4], f.fl[4]};
         end else begin
            w4[3] = f.ff[5] | f.fb[0];
            w4[2] = f.ff[6] | f.fb[6];
            w4[1] = ~|f.edge_occ[3:2];
         end
         w4[5] = n2[0];
         sp[4] = 1'b1;
      end

      // child 5
      w5 = 12'd0;
      if (nf) begin
         w5 = {6'd0, f.a_f[3:1], n3};
      end else begin
         w5[0] = ~nl;
         w5[1] = ~nb;
         w5[2] = ~|f.edge_occ[5:2];
         w5[3] = ~f.any_occ[5];
         w5[4] = n3[0];
         w5[5] = n3[2];
         sp[5] = 1'b1;
      end

      // child 6
      w6 = 12'd0;
      if (nb) begin
         w6 = {7'd0, f.a_b[3:1], 1'b0, n2[0]} | {10'd0, n2};
      end else begin
         w6[0]   = ~nl;
         w6[1]   = ~nf;
         w6[2]   = ~(f.edge_occ[1] | f.edge_occ[3]);
         w6[3]   = ~f.any_occ[6];
         w6[5:4] = n2;
         sp[6] = 1'b1;
      end

      rsp.word0       = w0;
      rsp.word1       = w1;
      rsp.word2       = w2;
      rsp.word3       = w3;
      rsp.word4       = w4;
      rsp.word5       = w5;
      rsp.word6       = w6;
      rsp.word7       = {9'd0, n3};
      rsp.sparse_mask = sp;
   end

endmodule

[rtl/octree_adjacent_child_context_words.sv]
// A start transfer passes through feat_ff, cntd_ff and rsp_ff, in that order, to the rsp_valid strobe.
// Throughput: one node per cycle; the three register stages never stall.
// busy is high only while reset is asserted; results cannot be held off.
// Synchronous active-high reset clears the stage valid bits; payload is not reset.
// Top level of the octree child context word pipeline.
`timescale 1ns / 1ps
module octree_adjacent_child_context_words (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ocwd_pkg::req_type req_data,
   output logic              rsp_valid,
   output ocwd_pkg::rsp_type rsp_data
);

   ocwd_pkg::feat_type feat_in;
   ocwd_pkg::feat_type feat_ff;
   ocwd_pkg::cntd_type cntd_in;
   ocwd_pkg::cntd_type cntd_ff;
   ocwd_pkg::rsp_type  rsp_in;
   ocwd_pkg::rsp_type  rsp_ff;
   logic               v1_ff;
   logic               v2_ff;
   logic               v3_ff;
   logic               accept;

   assign busy   = reset;
   assign accept = start && !busy;

   ocwd_prep u_prep (
      .req_data (req_data),
      .feat     (feat_in)
   );

   ocwd_count u_count (
      .feat (feat_ff),
      .cntd (cntd_in)
   );

   ocwd_words u_words (
      .cntd (cntd_ff),
      .rsp  (rsp_in)
   );

   // advance every stage each cycle; valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      feat_ff <= feat_in;
      cntd_ff <= cntd_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result strobe without a matching start transfer");

   a_none_lost: assert property (@(posedge clock) disable iff (reset)
      v2_ff |=> rsp_valid)
      else $error("item in the count stage did not reach the output");

   a_sparse5_low_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sparse_mask[5] |-> rsp_data.word5[11:6] == 6'd0)
      else $error("sparse word 5 has upper bits set");

   a_sparse6_low_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sparse_mask[6] |-> rsp_data.word6[11:6] == 6'd0)
      else $error("sparse word 6 has upper bits set");
`endif

endmodule

[tb/sv/tb_octree_adjacent_child_context_words.sv]
// Self-checking testbench for the octree child context word block: directed and random nodes.
`timescale 1ns / 1ps
module tb_octree_adjacent_child_context_words;
   import ocwd_pkg::*;

   localparam int NodeCount  = 1700;
   localparam int CycleLimit = 400000;
   localparam int DrainEvery = 400;
   localparam int SettleWait = 8;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type nodes_pending[$];
   rsp_type context_words_due[$];
   int      failures     = 0;
   int      cycle_count  = 0;
   int      nodes_sent   = 0;
   int      gap_left     = 0;
   int      burst_left   = 0;
   logic    drain_hold   = 1'b0;

   octree_adjacent_child_context_words dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned nonzero(input int unsigned v);
      return (v != 0) ? 1 : 0;
   endfunction

   function automatic int unsigned zero(input int unsigned v);
      return (v == 0) ? 1 : 0;
   endfunction

   // context words and sparse mask for one node
   function automatic rsp_type predict_context_words(input req_type node);
      int unsigned pat, left_b, front_b, bottom_b, adj_l, adj_f, adj_b, any_b;
      int unsigned edge_bits, rbt3, rbt2, cnt, cnt_n, lfb, sparse;
      int unsigned w[8];
      rsp_type     res;
      pat      = node.neigh_pattern;
      left_b   = pat[1] ? node.occ_left : 0;
      front_b  = pat[2] ? node.occ_front : 0;
      bottom_b = pat[4] ? node.occ_bottom : 0;
      adj_l    = left_b >> 4;
      adj_f    = ((front_b >> 2) & 3) | ((front_b >> 4) & 12);
      adj_b    = ((bottom_b >> 1) & 1) | ((bottom_b >> 2) & 2) | ((bottom_b >> 3) & 4)
               | ((bottom_b >> 4) & 8);
      any_b    = left_b | front_b | bottom_b;
      edge_bits = 0;
      if (node.left_bottom_present)
         edge_bits |= ((node.occ_left_bottom & 32) >> 5) | ((node.occ_left_bottom & 128) >> 6);
      if (node.front_bottom_present)
         edge_bits |= ((node.occ_front_bottom & 8) >> 1) | ((node.occ_front_bottom & 128) >> 4);
      if (node.left_front_present)
         edge_bits |= (node.occ_left_front & 'hC0) >> 2;
      rbt3   = ((pat >> 3) & 4) | ((pat >> 2) & 2) | (pat & 1);
      rbt2   = rbt3 & 3;
      sparse = 0;

      cnt   = $countones(adj_l) + $countones(adj_f) + $countones(adj_b);
      cnt_n = nonzero(adj_l) + nonzero(adj_f) + nonzero(adj_b);
      w[0]  = 0;
      if (cnt > 1) begin
         if (cnt_n == 3) begin
            w[0] = {SelTriple, 8'h00} | (adj_l & 7) | ((adj_f & 7) << 3) | ((adj_b & 7) << 6);
         end else if (cnt_n == 2) begin
            // later pairs take precedence
            if (adj_l != 0 && adj_b != 0) w[0] = {SelLb, 8'h00} | adj_l | (adj_b << 4);
            if (adj_f != 0 && adj_b != 0) w[0] = {SelFb, 8'h00} | adj_f | (adj_b << 4);
            if (adj_l != 0 && adj_f != 0) w[0] = {SelLf, 8'h00} | adj_l | (adj_f << 4);
         end else begin
            if (adj_l != 0) w[0] = (adj_l << 4) | (edge_bits & 'h0C);
            if (adj_f != 0)
               w[0] = {SelFront, 8'h00} | (adj_f << 4) | ((edge_bits & 'h03) << 2);
            if (adj_b != 0)
               w[0] = {SelBottom, 8'h00} | (adj_b << 4) | ((edge_bits & 'h30) >> 2);
         end
      end else begin
         lfb  = ((pat & 6) >> 1) | ((pat & 16) >> 2);
         w[0] = lfb << 4;
         if (cnt != 0) begin
            if (adj_l != 0) w[0] |= 1 << 7;
            if (adj_f != 0) w[0] |= 2 << 7;
            if (adj_b != 0) w[0] |= 3 << 7;
         end
         if (lfb != 0) begin
            if (any_b & 1) begin
               w[0] |= 8 | (left_b & 1) | ((front_b & 1) << 1) | ((bottom_b & 1) << 2);
            end else begin
               w[0] |= nonzero((left_b & 2) | (front_b & 16) | (bottom_b & 16));
               w[0] |= nonzero((left_b & 4) | (front_b & 2) | (bottom_b & 4)) << 1;
               w[0] |= zero(edge_bits) << 2;
            end
         end else begin
            w[0] |= zero(edge_bits & 'h03) << 1;
            w[0] |= zero(edge_bits & 'h0C) << 2;
            w[0] |= zero(edge_bits & 'h30) << 3;
         end
         sparse |= 1;
      end

      if (adj_l != 0 || adj_f != 0) begin
         w[1] = (adj_l << 3) | (adj_f << 7) | rbt3;
      end else begin
         w[1] = (rbt3 >> 2) << 5;
         if (any_b & 2) begin
            w[1] |= 16 | (left_b & 2) | ((front_b & 2) << 1) | ((bottom_b & 2) << 2);
         end else begin
            w[1] |= nonzero((left_b & 1) | (front_b & 1)) << 1;
            w[1] |= nonzero((left_b & 8) | (front_b & 32)) << 2;
            w[1] |= zero(edge_bits & 'h35) << 3;
         end
         w[1] |= zero(adj_b);
         sparse |= 2;
      end

      if (adj_l != 0 || adj_b != 0) begin
         w[2] = (adj_l << 2) | (adj_b << 6) | rbt2;
      end else begin
         w[2] = zero(adj_f);
         if (any_b & 4) begin
            w[2] |= 16 | ((left_b & 4) << 1) | (bottom_b & 4) | ((front_b & 4) >> 1);
         end else begin
            w[2] |= nonzero((left_b & 1) | (bottom_b & 1)) << 3;
            w[2] |= nonzero((left_b & 8) | (bottom_b & 64)) << 2;
            w[2] |= zero(edge_bits & 'h03) << 1;
         end
         w[2] |= ((rbt2 >> 1) & 1) << 5;
         sparse |= 4;
      end

      if (adj_l != 0) begin
         w[3] = (adj_l << 3) | rbt3;
      end else begin
         w[3] = zero(adj_f) | (zero(adj_b) << 1);
         if (any_b & 8) begin
            w[3] |= 32 | ((left_b & 8) >> 1) | (front_b & 8) | ((bottom_b & 8) << 1);
         end else begin
            w[3] |= (left_b & 6) << 2;
            w[3] |= zero(edge_bits & 'h32) << 2;
         end
         w[3] |= (rbt3 >> 1) << 6;
         sparse |= 8;
      end

      if (adj_f != 0 || adj_b != 0) begin
         w[4] = (((adj_f & 1) | ((adj_f >> 1) & 6)) << 2)
              | (((adj_b & 1) | ((adj_b >> 1) & 6)) << 5) | rbt2;
      end else begin
         w[4] = zero(adj_l);
         if (any_b & 16) begin
            w[4] |= 16 | ((front_b & 16) >> 1) | ((bottom_b & 16) >> 2) | ((left_b & 16) >> 3);
         end else begin
            w[4] |= nonzero((front_b & 32) | (bottom_b & 1)) << 3;
            w[4] |= nonzero((front_b & 64) | (bottom_b & 64)) << 2;
            w[4] |= zero(edge_bits & 'h0C) << 1;
         end
         w[4] |= (rbt2 & 1) << 5;
         sparse |= 16;
      end

      if (adj_f != 0) begin
         w[5] = ((adj_f & 'hE) << 2) | rbt3;
      end else begin
         w[5] = zero(adj_l) | (zero(adj_b) << 1);
         w[5] |= zero(edge_bits & 'h3C) << 2;
         w[5] |= zero(any_b & 32) << 3;
         w[5] |= (rbt3 & 1) << 4;
         w[5] |= (rbt3 >> 2) << 5;
         sparse |= 32;
      end

      if (adj_b != 0) begin
         w[6] = ((adj_b & 'hE) << 1) | rbt2;
      end else begin
         w[6] = zero(adj_l) | (zero(adj_f) << 1);
         w[6] |= zero(edge_bits & 'h0A) << 2;
         w[6] |= zero(any_b & 64) << 3;
         w[6] |= rbt2 << 4;
         sparse |= 64;
      end

      w[7] = rbt3;

      res.word0       = w[0][11:0];
      res.word1       = w[1][11:0];
      res.word2       = w[2][11:0];
      res.word3       = w[3][11:0];
      res.word4       = w[4][11:0];
      res.word5       = w[5][11:0];
      res.word6       = w[6][11:0];
      res.word7       = w[7][11:0];
      res.sparse_mask = sparse[6:0];
      return res;
   endfunction

   task automatic add_node(input logic [5:0] pat, input logic [7:0] l, f, b, lb, fbt, lf,
                           input logic plb, pfb, plf);
      req_type node;
      node.neigh_pattern        = pat;
      node.occ_left             = l;
      node.occ_front            = f;
      node.occ_bottom           = b;
      node.occ_left_bottom      = lb;
      node.occ_front_bottom     = fbt;
      node.occ_left_front       = lf;
      node.left_bottom_present  = plb;
      node.front_bottom_present = pfb;
      node.left_front_present   = plf;
      nodes_pending.push_back(node);
   endtask

   // occupancy byte weighted towards sparse and dense extremes
   function automatic logic [7:0] rand_occ();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'h01 << $urandom_range(0, 7);
         2: return 8'($urandom_range(0, 15));
         3: return 8'($urandom_range(0, 15)) << 4;
         4: return 8'($urandom_range(0, 255));
         default: return 8'hFF;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(input string name, input int unsigned exp_v, act_v);
      if (exp_v != act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         failures++;
      end
   endtask

   // driver: one transfer per edge at most, random gaps (often none) between transfers
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            context_words_due.push_back(predict_context_words(req_data));
            nodes_sent++;
            gap_left = pick_gap();
            if (nodes_sent % DrainEvery == 0) drain_hold = 1'b1;
         end
         if (drain_hold && context_words_due.size() == 0) drain_hold = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (!drain_hold && nodes_pending.size() > 0) begin
            start    <= 1'b1;
            req_data <= nodes_pending.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is a transfer, compare with the oldest prediction
   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid) begin
         if (context_words_due.size() == 0) begin
            $error("result with no prediction waiting");
            failures++;
         end else begin
            due = context_words_due.pop_front();
            check_field("word0", due.word0, rsp_data.word0);
            check_field("word1", due.word1, rsp_data.word1);
            check_field("word2", due.word2, rsp_data.word2);
            check_field("word3", due.word3, rsp_data.word3);
            check_field("word4", due.word4, rsp_data.word4);
            check_field("word5", due.word5, rsp_data.word5);
            check_field("word6", due.word6, rsp_data.word6);
            check_field("word7", due.word7, rsp_data.word7);
            check_field("sparse_mask", due.sparse_mask, rsp_data.sparse_mask);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("octree_adjacent_child_context_words regression: fail");
         $finish;
      end
   end

   initial begin
      // extremes and gating
      add_node(6'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
      add_node(6'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
      add_node(6'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0);
      add_node(6'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
      for (int k = 0; k < 6; k++)
         add_node(6'h01 << k, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
      // all three adjacent halves, then each pair
      add_node(6'h16, 8'hF0, 8'hCC, 8'hAA, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
      add_node(6'h12, 8'hF0, 8'hFF, 8'hAA, 8'hA0, 8'h88, 8'hC0, 1'b1, 1'b1, 1'b1);
      add_node(6'h14, 8'hFF, 8'hCC, 8'hAA, 8'hA0, 8'h88, 8'hC0, 1'b1, 1'b1, 1'b1);
      add_node(6'h06, 8'hF0, 8'hCC, 8'hFF, 8'hA0, 8'h88, 8'hC0, 1'b1, 1'b1, 1'b1);
      // one neighbour with several adjacent children
      add_node(6'h02, 8'h30, 8'h00, 8'h00, 8'hA0, 8'h88, 8'hC0, 1'b1, 1'b1, 1'b1);
      add_node(6'h04, 8'h00, 8'hCC, 8'h00, 8'hA0, 8'h88, 8'hC0, 1'b1, 1'b1, 1'b1);
      add_node(6'h10, 8'h00, 8'h00, 8'hA0, 8'hA0, 8'h88, 8'hC0, 1'b1, 1'b1, 1'b1);
      // a single adjacent child
      add_node(6'h02, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
      add_node(6'h04, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
      add_node(6'h10, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
      // no adjacent child: far halves decide
      add_node(6'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
      add_node(6'h16, 8'h0E, 8'h32, 8'h55, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
      add_node(6'h29, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
      // edge neighbours alone, present and absent
      add_node(6'h00, 8'h00, 8'h00, 8'h00, 8'hA0, 8'h88, 8'hC0, 1'b1, 1'b1, 1'b1);
      add_node(6'h00, 8'h00, 8'h00, 8'h00, 8'hA0, 8'h88, 8'hC0, 1'b1, 1'b0, 1'b0);
      add_node(6'h00, 8'h00, 8'h00, 8'h00, 8'hA0, 8'h88, 8'hC0, 1'b0, 1'b1, 1'b0);
      add_node(6'h00, 8'h00, 8'h00, 8'h00, 8'hA0, 8'h88, 8'hC0, 1'b0, 1'b0, 1'b1);
      for (int n = 0; n < NodeCount; n++)
         add_node(6'($urandom_range(0, 63)), rand_occ(), rand_occ(), rand_occ(),
                  rand_occ(), rand_occ(), rand_occ(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (nodes_pending.size() != 0 || start || context_words_due.size() != 0)
         @(posedge clock);
      repeat (SettleWait) @(posedge clock);
      if (failures == 0 && context_words_due.size() == 0) begin
         $display("octree_adjacent_child_context_words regression: pass");
      end else begin
         $display("octree_adjacent_child_context_words regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/ocwd_pkg.sv
rtl/ocwd_prep.sv
rtl/ocwd_count.sv
rtl/ocwd_words.sv
rtl/octree_adjacent_child_context_words.sv
tb/sv/tb_octree_adjacent_child_context_words.sv
